// ===== design/min_max_contrast_stretch_top_defines.svh =====
// ---------------------------------------------------------------------------
// min_max_contrast_stretch_top_defines
// assertion macros for the contrast stretch block
// ---------------------------------------------------------------------------
`ifndef MIN_MAX_CONTRAST_STRETCH_TOP_DEFINES_SVH
`define MIN_MAX_CONTRAST_STRETCH_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MMCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mmcs assertion failed");
`define MMCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mmcs assertion failed");
`else
`define MMCS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MMCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/mmcs_pkg.sv =====
// ---------------------------------------------------------------------------
// mmcs_pkg
// shared constants and types of the contrast stretch block
// ---------------------------------------------------------------------------
`default_nettype none
package mmcs_pkg;

	localparam int FRAME_PIXELS = 65536;
	localparam int PIX_W        = 8;
	localparam int ADDR_W       = $clog2(FRAME_PIXELS);
	localparam int CNT_W        = $clog2(FRAME_PIXELS + 1);
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
	localparam logic [7:0]       OUT_MAX = 8'hff;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_READOUT = 1'b1;

	// one pending read-out with the extremes as they stood
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [PIX_W-1:0] min_val;
		logic [PIX_W-1:0] max_val;
		logic             last;
	} rd_entry_t;

	typedef struct packed {
		logic [QCNT_W-1:0] level;
		logic              empty;
	} q_stat_t;

endpackage
`default_nettype wire

// ===== design/mmcs_front.sv =====
// ---------------------------------------------------------------------------
// mmcs_front
// accepts beats, stores the frame, tracks extremes and issues read-outs
// ---------------------------------------------------------------------------
`default_nettype none
module mmcs_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      in_command,
	input  wire logic                      in_frame_start,
	input  wire logic [mmcs_pkg::PIX_W-1:0] in_pixel,
	input  wire mmcs_pkg::q_stat_t         q_stat,
	output logic                           push,
	output mmcs_pkg::rd_entry_t            push_entry
);

	logic [mmcs_pkg::PIX_W-1:0] mem [mmcs_pkg::FRAME_PIXELS];

	logic [mmcs_pkg::CNT_W-1:0] count_q;
	logic [mmcs_pkg::CNT_W-1:0] rptr_q;
	logic [mmcs_pkg::PIX_W-1:0] min_q;
	logic [mmcs_pkg::PIX_W-1:0] max_q;

	logic                       rd_s1;
	logic [mmcs_pkg::PIX_W-1:0] rdata_s1;
	logic [mmcs_pkg::PIX_W-1:0] min_s1;
	logic [mmcs_pkg::PIX_W-1:0] max_s1;
	logic                       last_s1;

	logic                         accept;
	logic                         do_load;
	logic                         do_read;
	logic                         do_write;
	logic [mmcs_pkg::ADDR_W-1:0]  wr_addr;
	logic [mmcs_pkg::QCNT_W:0]    used;

	assign used     = {1'b0, q_stat.level} + {{mmcs_pkg::QCNT_W{1'b0}}, rd_s1};
	assign in_ready = (used < (mmcs_pkg::QCNT_W + 1)'(mmcs_pkg::QUEUE_DEPTH));
	assign accept   = in_valid && in_ready;
	assign do_load  = accept && (in_command == mmcs_pkg::CMD_LOAD);
	assign do_read  = accept && (in_command == mmcs_pkg::CMD_READOUT) && (rptr_q < count_q);
	assign do_write = do_load &&
		(in_frame_start || (count_q < mmcs_pkg::CNT_W'(mmcs_pkg::FRAME_PIXELS)));
	assign wr_addr  = in_frame_start ? '0 : count_q[mmcs_pkg::ADDR_W-1:0];

	// frame store, registered read
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr_addr] <= in_pixel;
		end
		if (do_read) begin
			rdata_s1 <= mem[rptr_q[mmcs_pkg::ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rptr_q  <= '0;
			min_q   <= mmcs_pkg::PIX_MAX;
			max_q   <= '0;
			rd_s1   <= 1'b0;
		end else begin
			rd_s1 <= do_read;
			if (do_write) begin
				if (in_frame_start) begin
					count_q <= mmcs_pkg::CNT_W'(1);
					rptr_q  <= '0;
					min_q   <= in_pixel;
					max_q   <= in_pixel;
				end else begin
					count_q <= count_q + 1'b1;
					if (in_pixel < min_q) begin
						min_q <= in_pixel;
					end
					if (in_pixel > max_q) begin
						max_q <= in_pixel;
					end
				end
			end
			if (do_read) begin
				rptr_q <= rptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			min_s1  <= min_q;
			max_s1  <= max_q;
			last_s1 <= ((rptr_q + 1'b1) == count_q);
		end
	end

	assign push               = rd_s1;
	assign push_entry.pixel   = rdata_s1;
	assign push_entry.min_val = min_s1;
	assign push_entry.max_val = max_s1;
	assign push_entry.last    = last_s1;

endmodule
`default_nettype wire

// ===== design/mmcs_queue.sv =====
// ---------------------------------------------------------------------------
// mmcs_queue
// short fifo of pending read-outs between front and back
// ---------------------------------------------------------------------------
`default_nettype none
module mmcs_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire mmcs_pkg::rd_entry_t push_entry,
	input  wire logic                pop,
	output mmcs_pkg::rd_entry_t      head,
	output mmcs_pkg::q_stat_t        stat
);

	mmcs_pkg::rd_entry_t         slot_q [mmcs_pkg::QUEUE_DEPTH];
	logic [mmcs_pkg::QPTR_W-1:0] wptr_q;
	logic [mmcs_pkg::QPTR_W-1:0] rptr_q;
	logic [mmcs_pkg::QCNT_W-1:0] level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	assign head       = slot_q[rptr_q];
	assign stat.level = level_q;
	assign stat.empty = (level_q == '0);

endmodule
`default_nettype wire

// ===== design/mmcs_back.sv =====
// ---------------------------------------------------------------------------
// mmcs_back
// rescales one pixel by restoring division with half-even rounding
// ---------------------------------------------------------------------------
`default_nettype none
module mmcs_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mmcs_pkg::q_stat_t   q_stat,
	input  wire mmcs_pkg::rd_entry_t head,
	output logic                     pop,
	output logic                     busy,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [7:0]               out_pixel,
	output logic                     out_last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                 state_q;
	logic [2:0]                 step_q;
	mmcs_pkg::rd_entry_t        work_q;
	logic [mmcs_pkg::PIX_W-1:0] den_q;
	logic [mmcs_pkg::PIX_W-1:0] rem_q;
	logic [7:0]                 lo_q;
	logic [7:0]                 quo_q;

	logic                       out_valid_q;
	logic [7:0]                 out_pixel_q;
	logic                       out_last_q;

	logic [mmcs_pkg::PIX_W-1:0] diff;
	logic [15:0]                prod;
	logic [mmcs_pkg::PIX_W:0]   trial;
	logic                       fits;
	logic [mmcs_pkg::PIX_W:0]   twice_rem;
	logic                       round_up;
	logic [7:0]                 rounded;
	logic                       out_free;

	assign diff      = work_q.pixel - work_q.min_val;
	assign prod      = diff * mmcs_pkg::OUT_MAX;
	assign trial     = {rem_q, lo_q[7]};
	assign fits      = (trial >= {1'b0, den_q});
	assign twice_rem = {rem_q, 1'b0};
	assign round_up  = (twice_rem > {1'b0, den_q}) ||
		((twice_rem == {1'b0, den_q}) && quo_q[0]);
	assign rounded   = (round_up && (quo_q != mmcs_pkg::OUT_MAX)) ? quo_q + 1'b1 : quo_q;
	assign out_free  = !out_valid_q || out_ready;
	assign pop       = (state_q == ST_IDLE) && !q_stat.empty;
	assign busy      = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if ((work_q.max_val <= work_q.min_val) || (work_q.pixel <= work_q.min_val) ||
						(work_q.pixel >= work_q.max_val)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == 3'd7) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= head;
		end
		unique case (state_q)
			ST_PREP: begin
				step_q <= '0;
				if ((work_q.max_val <= work_q.min_val) || (work_q.pixel <= work_q.min_val)) begin
					quo_q <= '0;
					rem_q <= '0;
					den_q <= mmcs_pkg::PIX_W'(1);
				end else if (work_q.pixel >= work_q.max_val) begin
					quo_q <= mmcs_pkg::OUT_MAX;
					rem_q <= '0;
					den_q <= mmcs_pkg::PIX_W'(1);
				end else begin
					quo_q <= '0;
					rem_q <= prod[15:8];
					lo_q  <= prod[7:0];
					den_q <= work_q.max_val - work_q.min_val;
				end
			end
			ST_DIV: begin
				step_q <= step_q + 1'b1;
				lo_q   <= {lo_q[6:0], 1'b0};
				quo_q  <= {quo_q[6:0], fits};
				rem_q  <= fits ? mmcs_pkg::PIX_W'(trial - {1'b0, den_q})
				               : trial[mmcs_pkg::PIX_W-1:0];
			end
			ST_DONE: begin
				if (out_free) begin
					out_pixel_q <= rounded;
					out_last_q  <= work_q.last;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire

// ===== design/min_max_contrast_stretch_top.sv =====
// ---------------------------------------------------------------------------
// min_max_contrast_stretch_top
// min-max contrast stretch of one stored grayscale frame
// ---------------------------------------------------------------------------
// Load beats (tuser command 0) take one per cycle: each pixel is written to
// the frame store and widens the running minimum and maximum; frame_start on
// a load begins a new frame. Read-out beats (command 1) fetch the next stored
// pixel in load order and queue it with the extremes as they stand; a
// read-out with nothing left gives no output beat. Each queued pixel is
// rescaled to (p - min) * 255 / (max - min), rounded half to even, by a
// divider producing one quotient bit per cycle. One read-out holds the back
// end through taking from the queue, set-up, eight division steps and
// rounding, skipping the division steps at an extreme or in a flat frame.
// The four-entry queue lets read-outs and loads be accepted while the divider
// is busy; input beats of either kind are held off only while the queue and
// the fetch stage together hold four read-outs. No clearing pass is needed
// after reset.
`default_nettype none
`include "min_max_contrast_stretch_top_defines.svh"
module min_max_contrast_stretch_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // pixel_in
	input  wire logic [1:0] s_axis_tuser,  // command, frame_start
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // pixel_out
	output logic            m_axis_tlast   // last_pixel
);

	logic                q_push;
	logic                q_pop;
	logic                back_busy;
	mmcs_pkg::rd_entry_t q_in;
	mmcs_pkg::rd_entry_t q_head;
	mmcs_pkg::q_stat_t   q_stat;

	mmcs_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.in_command     (s_axis_tuser[0]),
		.in_frame_start (s_axis_tuser[1]),
		.in_pixel       (s_axis_tdata[mmcs_pkg::PIX_W-1:0]),
		.q_stat         (q_stat),
		.push           (q_push),
		.push_entry     (q_in)
	);

	mmcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.pop        (q_pop),
		.head       (q_head),
		.stat       (q_stat)
	);

	mmcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head      (q_head),
		.pop       (q_pop),
		.busy      (back_busy),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pixel (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	`MMCS_ASSERT_IMPL(a_push_room, clk, arst_n, q_push && !q_pop, q_stat.level < mmcs_pkg::QCNT_W'(mmcs_pkg::QUEUE_DEPTH))
	`MMCS_ASSERT_IMPL(a_pop_filled, clk, arst_n, q_pop, !q_stat.empty && !back_busy)
	`MMCS_ASSERT_NEXT(a_pop_starts, clk, arst_n, q_pop, back_busy)

endmodule
`default_nettype wire
